[hdl/lpsg_pkg.sv]
// Shared types and constants of the laser point scan guard.
// Holds the sequencer state type, register indexes and the colour helpers.
// No dependencies.
package lpsg_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int HIST_MAX      = HISTORY_DEPTH - 1;

   localparam int DATA_W     = 112;
   localparam int ROOT_STEPS = 17;
   localparam int DIV_STEPS  = 36;

   localparam logic [2:0] CSR_MODE       = 3'd0;
   localparam logic [2:0] CSR_PROT_OFF   = 3'd1;
   localparam logic [2:0] CSR_PER_AXIS   = 3'd2;
   localparam logic [2:0] CSR_MAX_STEP   = 3'd3;
   localparam logic [2:0] CSR_MIN_STEP   = 3'd4;
   localparam logic [2:0] CSR_BRIGHTNESS = 3'd5;
   localparam logic [2:0] CSR_ALIGN      = 3'd6;

   // ceil(2^29 / 100): n * AVG_RECIP >> 29 equals n / 100 for every n below 2^22
   localparam logic [23:0] AVG_RECIP   = 24'd5368710;
   localparam logic [15:0] AVG_KEEP    = 16'd99;
   localparam logic [15:0] AVG_PUSH    = 16'd98;
   localparam logic [15:0] AVG_ONE     = 16'd32768;
   localparam logic [35:0] AVG_MOVE    = 36'd32768;
   localparam logic [35:0] AVG_BOOST   = 36'd65536;

   typedef enum logic [35:0] {
      ST_IDLE  = 36'h000000001,
      ST_COL0  = 36'h000000002,
      ST_COL1  = 36'h000000004,
      ST_COL2  = 36'h000000008,
      ST_SLEW  = 36'h000000010,
      ST_AXIS  = 36'h000000020,
      ST_SQ0   = 36'h000000040,
      ST_SQ1   = 36'h000000080,
      ST_SQ2   = 36'h000000100,
      ST_SQ3   = 36'h000000200,
      ST_ROOT  = 36'h000000400,
      ST_DVXM  = 36'h000000800,
      ST_DVXL  = 36'h000001000,
      ST_DIV   = 36'h000002000,
      ST_DVXE  = 36'h000004000,
      ST_DVYL  = 36'h000008000,
      ST_DVYE  = 36'h000010000,
      ST_SLWR  = 36'h000020000,
      ST_DW0   = 36'h000040000,
      ST_DW1   = 36'h000080000,
      ST_DW2   = 36'h000100000,
      ST_DW3   = 36'h000200000,
      ST_DW4   = 36'h000400000,
      ST_DW5   = 36'h000800000,
      ST_AVG1E = 36'h001000000,
      ST_AVG2L = 36'h002000000,
      ST_AVG2E = 36'h004000000,
      ST_FADE0 = 36'h008000000,
      ST_FADE1 = 36'h010000000,
      ST_FADE2 = 36'h020000000,
      ST_FADE3 = 36'h040000000,
      ST_FADE4 = 36'h080000000,
      ST_HIST  = 36'h100000000,
      ST_OUT   = 36'h200000000,
      ST_AVG1M = 36'h400000000,
      ST_AVG2M = 36'h800000000
   } state_type;

   // Brightness product in Q8.8 down to a 24-bit colour, clamped unless told not to.
   function automatic logic [23:0] gain_colour(input logic [31:0] p, input logic no_clamp);
      logic [23:0] c;
      c = p[31:8];
      if (!no_clamp && (c[23:16] != 8'd0)) begin
         c = 24'h00FFFF;
      end
      return c;
   endfunction

   function automatic logic [15:0] sat_colour(input logic [23:0] c);
      return (c[23:16] != 8'd0) ? 16'hFFFF : c[15:0];
   endfunction

endpackage

[hdl/laser_point_scan_guard_unit.sv]
// Laser point scan guard: colour gain, slew limit, dwell fade and colour/position alignment.
// One sequencer drives one shared multiplier and one shared subtractor (root and divide).
// Depends on lpsg_pkg.
//
// Latency is longest when the 2D slew limit and the dwell fade both run; it is set by the
// bit-serial root (17 steps) and two 36-step divisions on the shared subtractor. The unit
// takes no new point until the current one has passed to the output register, and a point
// waits in its last step while the previous result is still held there. Reset (synchronous)
// restores register defaults and clears all slew, dwell and history state at once.
module laser_point_scan_guard_unit
   import lpsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // pos_x, pos_y, pos_z, red_in, green_in, blue_in, extra_in (16 bits each, low first)
   input  logic [DATA_W-1:0]   req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // out_x, out_y, out_z, red_out, green_out, blue_out, extra_out (16 bits each, low first)
   output logic [DATA_W-1:0]   rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);

   state_type state_ff, state_in, div_ret_ff, div_ret_in;

   logic [2:0]  mode_ff;
   logic        prot_off_ff, per_axis_ff;
   logic [15:0] max_step_ff, min_step_ff, bright_ff;
   logic signed [4:0] align_ff;

   logic signed [15:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [15:0] red_ff, red_in, grn_ff, grn_in, blu_ff, blu_in, ext_ff, ext_in;
   logic [23:0] col0_ff, col0_in, col1_ff, col1_in, col2_ff, col2_in;
   logic signed [15:0] slx_ff, slx_in, sly_ff, sly_in, dwx_ff, dwx_in, dwy_ff, dwy_in;
   logic [15:0] avg_ff, avg_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [34:0] acc_ff, acc_in;
   logic signed [49:0] prod_ff, prod_in;
   logic [35:0] num_ff, num_in;
   logic [18:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [17:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        moved_ff, moved_in;
   logic [15:0] g_ff, g_in;
   logic [47:0] hp_ff [HISTORY_DEPTH];
   logic [63:0] hc_ff [HISTORY_DEPTH];
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic signed [24:0] mul_a, mul_b;
   logic [20:0] sub_a, sub_b;
   logic [21:0] diff;
   logic        ge;
   logic [16:0] lim, mlim, absdx, absdy;
   logic signed [18:0] dxw, dyw, limw, clx, cly;
   logic [18:0] five_a;
   logic signed [7:0] off_w;
   logic [HIST_AW-1:0] co, po;
   logic        hist_shift;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign lim   = {max_step_ff, 1'b0};
   assign mlim  = {min_step_ff, 1'b0};
   assign absdx = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign absdy = dy_ff[16] ? 17'(-dy_ff) : 17'(dy_ff);

   // Shared subtractor: root trial in ROOT, divisor trial otherwise
   always_comb begin
      if (state_ff == ST_ROOT) begin
         sub_a = {rem_ff, num_ff[35:34]};
         sub_b = {2'b00, root_ff, 2'b01};
      end else begin
         sub_a = {1'b0, rem_ff, num_ff[35]};
         sub_b = {3'b000, den_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[21];
   end

   // Per-axis clamp
   always_comb begin
      dxw  = {{2{dx_ff[16]}}, dx_ff};
      dyw  = {{2{dy_ff[16]}}, dy_ff};
      limw = signed'({2'b00, lim});
      clx  = (dxw > limw) ? limw : ((dxw < -limw) ? -limw : dxw);
      cly  = (dyw > limw) ? limw : ((dyw < -limw) ? -limw : dyw);
   end

   assign five_a = {1'b0, avg_ff, 2'b00} + {3'b000, avg_ff};

   // Offset clamp and history taps
   always_comb begin
      off_w = {{3{align_ff[4]}}, align_ff};
      if (off_w < -8'(HIST_MAX)) off_w = -8'(HIST_MAX);
      if (off_w > 8'(HIST_MAX))  off_w = 8'(HIST_MAX);
      co = (off_w > 8'sd0) ? HIST_AW'(off_w) : '0;
      po = (off_w < 8'sd0) ? HIST_AW'(-off_w) : '0;
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_COL0: begin
            mul_a = {9'd0, red_ff};
            mul_b = {9'd0, bright_ff};
         end
         ST_COL1: begin
            mul_a = {9'd0, grn_ff};
            mul_b = {9'd0, bright_ff};
         end
         ST_COL2: begin
            mul_a = {9'd0, blu_ff};
            mul_b = {9'd0, bright_ff};
         end
         ST_SQ0, ST_DW1: begin
            mul_a = {{8{dx_ff[16]}}, dx_ff};
            mul_b = {{8{dx_ff[16]}}, dx_ff};
         end
         ST_SQ1, ST_DW2: begin
            mul_a = {{8{dy_ff[16]}}, dy_ff};
            mul_b = {{8{dy_ff[16]}}, dy_ff};
         end
         ST_SQ2: begin
            mul_a = {8'd0, lim};
            mul_b = {8'd0, lim};
         end
         ST_DW3: begin
            mul_a = {8'd0, mlim};
            mul_b = {8'd0, mlim};
         end
         ST_DVXM: begin
            mul_a = {8'd0, absdx};
            mul_b = {8'd0, lim};
         end
         ST_DVXE: begin
            mul_a = {8'd0, absdy};
            mul_b = {8'd0, lim};
         end
         ST_DW4: begin
            mul_a = {9'd0, avg_ff};
            mul_b = {9'd0, AVG_KEEP};
         end
         // divide by 100 through the reciprocal
         ST_AVG1M, ST_AVG2M: begin
            mul_a = {1'b0, num_ff[23:0]};
            mul_b = {1'b0, AVG_RECIP};
         end
         ST_AVG1E: begin
            mul_a = {9'd0, prod_ff[44:29]};
            mul_b = {9'd0, AVG_PUSH};
         end
         ST_FADE1: begin
            mul_a = {1'b0, col0_ff};
            mul_b = {9'd0, g_ff};
         end
         ST_FADE2: begin
            mul_a = {1'b0, col1_ff};
            mul_b = {9'd0, g_ff};
         end
         ST_FADE3: begin
            mul_a = {1'b0, col2_ff};
            mul_b = {9'd0, g_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      div_ret_in   = div_ret_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      red_in       = red_ff;
      grn_in       = grn_ff;
      blu_in       = blu_ff;
      ext_in       = ext_ff;
      col0_in      = col0_ff;
      col1_in      = col1_ff;
      col2_in      = col2_ff;
      slx_in       = slx_ff;
      sly_in       = sly_ff;
      dwx_in       = dwx_ff;
      dwy_in       = dwy_ff;
      avg_in       = avg_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      moved_in     = moved_ff;
      g_in         = g_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      hist_shift   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata[15:0];
               py_in    = req_tdata[31:16];
               pz_in    = req_tdata[47:32];
               red_in   = req_tdata[63:48];
               grn_in   = req_tdata[79:64];
               blu_in   = req_tdata[95:80];
               ext_in   = req_tdata[111:96];
               state_in = ST_COL0;
            end
         end
         ST_COL0: state_in = ST_COL1;
         ST_COL1: begin
            col0_in  = gain_colour(prod_ff[31:0], mode_ff[2]);
            state_in = ST_COL2;
         end
         ST_COL2: begin
            col1_in  = gain_colour(prod_ff[31:0], mode_ff[2]);
            state_in = ST_SLEW;
         end
         ST_SLEW: begin
            col2_in = gain_colour(prod_ff[31:0], mode_ff[2]);
            dx_in   = 17'(px_ff) - 17'(slx_ff);
            dy_in   = 17'(py_ff) - 17'(sly_ff);
            if (prot_off_ff)      state_in = ST_HIST;
            else if (mode_ff[1])  state_in = ST_DW0;
            else if (per_axis_ff) state_in = ST_AXIS;
            else                  state_in = ST_SQ0;
         end
         ST_AXIS: begin
            px_in    = slx_ff + clx[15:0];
            py_in    = sly_ff + cly[15:0];
            slx_in   = slx_ff + clx[15:0];
            sly_in   = sly_ff + cly[15:0];
            state_in = ST_DW0;
         end
         ST_SQ0: state_in = ST_SQ1;
         ST_SQ1: begin
            acc_in   = prod_ff[34:0];
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            acc_in   = acc_ff + prod_ff[34:0];
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            if (acc_ff > prod_ff[34:0]) begin
               num_in   = {acc_ff[33:0], 2'b00};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_SLWR;
            end
         end
         ST_ROOT: begin
            rem_in  = ge ? diff[18:0] : sub_a[18:0];
            root_in = {root_ff[15:0], ge};
            num_in  = {num_ff[33:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_STEPS - 1)) state_in = ST_DVXM;
         end
         ST_DVXM: state_in = ST_DVXL;
         ST_DVXL: begin
            num_in     = prod_ff[35:0];
            rem_in     = '0;
            den_in     = {1'b0, root_ff};
            cnt_in     = '0;
            div_ret_in = ST_DVXE;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? diff[18:0] : sub_a[18:0];
            num_in = {num_ff[34:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = div_ret_ff;
         end
         ST_DVXE: begin
            dx_in    = dx_ff[16] ? -signed'(num_ff[16:0]) : signed'(num_ff[16:0]);
            state_in = ST_DVYL;
         end
         ST_DVYL: begin
            num_in     = prod_ff[35:0];
            rem_in     = '0;
            den_in     = {1'b0, root_ff};
            cnt_in     = '0;
            div_ret_in = ST_DVYE;
            state_in   = ST_DIV;
         end
         ST_DVYE: begin
            dy_in    = dy_ff[16] ? -signed'(num_ff[16:0]) : signed'(num_ff[16:0]);
            state_in = ST_SLWR;
         end
         ST_SLWR: begin
            px_in    = slx_ff + dx_ff[15:0];
            py_in    = sly_ff + dy_ff[15:0];
            slx_in   = slx_ff + dx_ff[15:0];
            sly_in   = sly_ff + dy_ff[15:0];
            state_in = ST_DW0;
         end
         ST_DW0: begin
            // black point or underscan skipped: leave dwell state alone
            if (({col0_ff, col1_ff, col2_ff} == '0) || mode_ff[0]) begin
               state_in = ST_HIST;
            end else begin
               dx_in    = 17'(px_ff) - 17'(dwx_ff);
               dy_in    = 17'(py_ff) - 17'(dwy_ff);
               state_in = ST_DW1;
            end
         end
         ST_DW1: state_in = ST_DW2;
         ST_DW2: begin
            acc_in   = prod_ff[34:0];
            state_in = ST_DW3;
         end
         ST_DW3: begin
            acc_in   = acc_ff + prod_ff[34:0];
            state_in = ST_DW4;
         end
         ST_DW4: begin
            moved_in = acc_ff > prod_ff[34:0];
            if (acc_ff > prod_ff[34:0]) begin
               dwx_in = px_ff;
               dwy_in = py_ff;
            end
            state_in = ST_DW5;
         end
         ST_DW5: begin
            num_in   = prod_ff[35:0] + (moved_ff ? AVG_MOVE : 36'd0);
            state_in = ST_AVG1M;
         end
         ST_AVG1M: state_in = ST_AVG1E;
         ST_AVG1E: begin
            avg_in   = prod_ff[44:29];
            state_in = moved_ff ? ST_AVG2L : ST_FADE0;
         end
         ST_AVG2L: begin
            num_in   = prod_ff[35:0] + AVG_BOOST;
            state_in = ST_AVG2M;
         end
         ST_AVG2M: state_in = ST_AVG2E;
         ST_AVG2E: begin
            avg_in   = prod_ff[44:29];
            state_in = ST_FADE0;
         end
         ST_FADE0: begin
            if (!moved_ff && (five_a < 19'd65536)) begin
               g_in     = (five_a > {3'b000, AVG_ONE}) ? AVG_ONE : five_a[15:0];
               state_in = ST_FADE1;
            end else begin
               state_in = ST_HIST;
            end
         end
         ST_FADE1: state_in = ST_FADE2;
         ST_FADE2: begin
            col0_in  = prod_ff[38:15];
            state_in = ST_FADE3;
         end
         ST_FADE3: begin
            col1_in  = prod_ff[38:15];
            state_in = ST_FADE4;
         end
         ST_FADE4: begin
            col2_in  = prod_ff[38:15];
            state_in = ST_HIST;
         end
         ST_HIST: begin
            hist_shift = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {hc_ff[co], hp_ff[po]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_ret_ff   <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         prot_off_ff  <= 1'b0;
         per_axis_ff  <= 1'b0;
         max_step_ff  <= 16'd16384;
         min_step_ff  <= '0;
         bright_ff    <= 16'd256;
         align_ff     <= '0;
         slx_ff       <= '0;
         sly_ff       <= '0;
         dwx_ff       <= '0;
         dwy_ff       <= '0;
         avg_ff       <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hp_ff[i] <= '0;
            hc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         div_ret_ff   <= div_ret_in;
         rsp_valid_ff <= rsp_valid_in;
         slx_ff       <= slx_in;
         sly_ff       <= sly_in;
         dwx_ff       <= dwx_in;
         dwy_ff       <= dwy_in;
         avg_ff       <= avg_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:       mode_ff     <= csr_data[2:0];
               CSR_PROT_OFF:   prot_off_ff <= csr_data[0];
               CSR_PER_AXIS:   per_axis_ff <= csr_data[0];
               CSR_MAX_STEP:   max_step_ff <= csr_data;
               CSR_MIN_STEP:   min_step_ff <= csr_data;
               CSR_BRIGHTNESS: bright_ff   <= csr_data;
               CSR_ALIGN:      align_ff    <= signed'(csr_data[4:0]);
               default: ;
            endcase
         end
         if (hist_shift) begin
            for (int i = HISTORY_DEPTH - 1; i >= 1; i--) begin
               hp_ff[i] <= hp_ff[i-1];
               hc_ff[i] <= hc_ff[i-1];
            end
            hp_ff[0] <= {pz_ff, py_ff, px_ff};
            hc_ff[0] <= {ext_ff, sat_colour(col2_ff), sat_colour(col1_ff),
                         sat_colour(col0_ff)};
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      red_ff      <= red_in;
      grn_ff      <= grn_in;
      blu_ff      <= blu_in;
      ext_ff      <= ext_in;
      col0_ff     <= col0_in;
      col1_ff     <= col1_in;
      col2_ff     <= col2_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      moved_ff    <= moved_in;
      g_ff        <= g_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != 18'd0))
      else $error("divide with zero divisor");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      (avg_ff <= AVG_ONE))
      else $error("move average above one");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output step");

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (cnt_ff < 6'(ROOT_STEPS)))
      else $error("root step count overrun");

endmodule

[tb/lpsg_checker.sv]
// Scoreboard for the laser point scan guard: predicts each output point and compares it.
// Watches the request, response and register channels of the unit.
// Depends on lpsg_pkg.
module lpsg_checker
   import lpsg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output int                fail_count,
   output int                pending
);

   logic [2:0]  mode_q;
   logic        prot_off_q;
   logic        per_axis_q;
   logic [15:0] max_step_q;
   logic [15:0] min_step_q;
   logic [15:0] bright_q;
   logic signed [4:0] align_q;

   int          slew_x, slew_y, dwell_x, dwell_y;
   int unsigned move_avg;
   logic [47:0] pos_hist [HISTORY_DEPTH];
   logic [63:0] col_hist [HISTORY_DEPTH];

   logic [DATA_W-1:0] expected_points [$];
   int mismatches;

   string field_name [7] = '{"out_x", "out_y", "out_z", "red_out", "green_out",
                             "blue_out", "extra_out"};

   function automatic longint unsigned int_root(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] guard_point(logic [DATA_W-1:0] d);
      int px, py, dx, dy, lim, off, co, po;
      longint unsigned s, dlim;
      longint r;
      int unsigned col [3];
      int unsigned g;
      bit moved;
      logic [DATA_W-1:0] o;
      px = int'($signed(d[15:0]));
      py = int'($signed(d[31:16]));
      for (int k = 0; k < 3; k++) begin
         col[k] = int'((longint'(d[48+16*k +: 16]) * longint'(bright_q)) >> 8);
         if (!mode_q[2] && col[k] > 65535) col[k] = 65535;
      end
      if (!prot_off_q) begin
         if (!mode_q[1]) begin
            lim = 2 * int'(max_step_q);
            dx = px - slew_x;
            dy = py - slew_y;
            if (!per_axis_q) begin
               s = longint'(dx) * dx + longint'(dy) * dy;
               if (s > longint'(lim) * lim) begin
                  r = longint'(int_root(s));
                  dx = int'((longint'(dx) * lim) / r);
                  dy = int'((longint'(dy) * lim) / r);
               end
            end else begin
               if (dx > lim) dx = lim;
               if (dx < -lim) dx = -lim;
               if (dy > lim) dy = lim;
               if (dy < -lim) dy = -lim;
            end
            px = slew_x + dx;
            py = slew_y + dy;
            slew_x = px;
            slew_y = py;
         end
         if ((col[0] | col[1] | col[2]) != 0 && !mode_q[0]) begin
            dx = px - dwell_x;
            dy = py - dwell_y;
            dlim = 2 * longint'(min_step_q);
            moved = (longint'(dx) * dx + longint'(dy) * dy) > dlim * dlim;
            if (moved) begin
               dwell_x = px;
               dwell_y = py;
            end
            move_avg = (99 * move_avg + (moved ? 32768 : 0)) / 100;
            if (moved) move_avg = (98 * move_avg + 65536) / 100;
            if (!moved && move_avg * 5 < 65536) begin
               g = move_avg * 5;
               if (g > 32768) g = 32768;
               for (int k = 0; k < 3; k++) col[k] = int'((longint'(col[k]) * g) >> 15);
            end
         end
      end
      for (int i = HISTORY_DEPTH - 1; i >= 1; i--) begin
         pos_hist[i] = pos_hist[i-1];
         col_hist[i] = col_hist[i-1];
      end
      pos_hist[0] = {d[47:32], py[15:0], px[15:0]};
      for (int k = 0; k < 3; k++)
         col_hist[0][16*k +: 16] = (col[k] > 65535) ? 16'hFFFF : col[k][15:0];
      col_hist[0][63:48] = d[111:96];
      off = int'(align_q);
      if (off < -HIST_MAX) off = -HIST_MAX;
      if (off > HIST_MAX) off = HIST_MAX;
      co = (off > 0) ? off : 0;
      po = (off < 0) ? -off : 0;
      o = {col_hist[co], pos_hist[po]};
      return o;
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] exp_point;
      bit bad;
      if (reset) begin
         mode_q = 3'd0;
         prot_off_q = 1'b0;
         per_axis_q = 1'b0;
         max_step_q = 16'd16384;
         min_step_q = 16'd0;
         bright_q = 16'd256;
         align_q = 5'sd0;
         slew_x = 0; slew_y = 0; dwell_x = 0; dwell_y = 0;
         move_avg = 0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            pos_hist[i] = '0;
            col_hist[i] = '0;
         end
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:       mode_q = csr_data[2:0];
               CSR_PROT_OFF:   prot_off_q = csr_data[0];
               CSR_PER_AXIS:   per_axis_q = csr_data[0];
               CSR_MAX_STEP:   max_step_q = csr_data;
               CSR_MIN_STEP:   min_step_q = csr_data;
               CSR_BRIGHTNESS: bright_q = csr_data;
               CSR_ALIGN:      align_q = csr_data[4:0];
               default: ;
            endcase
         end
         // a result here belongs to an older request, so check it before queueing one
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               fail_count++;
               if (mismatches < 10) $display("unexpected result %h", rsp_tdata);
               mismatches++;
            end else begin
               exp_point = expected_points.pop_front();
               bad = 0;
               for (int k = 0; k < 7; k++) begin
                  if (rsp_tdata[16*k +: 16] !== exp_point[16*k +: 16]) begin
                     bad = 1;
                     if (mismatches < 10)
                        $display("%s: expected %h, got %h", field_name[k],
                                 exp_point[16*k +: 16], rsp_tdata[16*k +: 16]);
                  end
               end
               if (bad) begin
                  fail_count++;
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_points = {expected_points, guard_point(req_tdata)};
      end
      pending = expected_points.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      mismatches = 0;
   end

endmodule

[tb/tb_laser_point_scan_guard_unit.sv]
// Top of the scan guard testbench: clock, reset, point and register stimulus, verdict.
// Depends on lpsg_pkg, laser_point_scan_guard_unit and lpsg_checker.
module tb_laser_point_scan_guard_unit;
   import lpsg_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = 3'd0;
   logic [15:0] csr_data = 16'd0;
   int fail_count, pending;

   int burst_left = 0;
   int points_sent = 0;
   int stall_cycle = 0;
   logic [15:0] last_x = 0, last_y = 0;

   always #1 clock = ~clock;

   laser_point_scan_guard_unit DUT (.*);

   lpsg_checker scoreboard (.*);

   // receiver: cycle through always-ready, coin-flip and mostly-stalled stretches
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 97) % 3)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(logic [15:0] x, y, z, r, g, b, e);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {e, b, g, r, z, y, x};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      last_x = x;
      last_y = y;
      points_sent++;
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // mostly short strokes and dwells from the last point, with jumps, blanking and noise
   task automatic random_point();
      logic [15:0] x, y, r, g, b;
      int pick, span;
      pick = $urandom_range(0, 19);
      span = $urandom_range(0, 3) == 0 ? 4000 : 300;
      x = last_x + 16'($signed($urandom_range(0, 2 * span)) - span);
      y = last_y + 16'($signed($urandom_range(0, 2 * span)) - span);
      r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
      if (pick < 4) begin
         x = last_x;
         y = last_y;
      end else if (pick < 7) begin
         x = 16'($urandom);
         y = 16'($urandom);
      end else if (pick == 7) begin
         r = 0; g = 0; b = 0;
      end else if (pick == 8) begin
         r = 16'($urandom_range(0, 3)); g = 0; b = 16'($urandom_range(0, 1));
      end else if (pick == 9) begin
         x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         y = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      send_point(x, y, 16'($urandom), r, g, b, 16'($urandom));
   endtask

   task automatic directed_points();
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_point(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_point(16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h5555);
      send_point(16'h8000, 16'h7FFF, 16'h1234, 16'h8000, 16'h4000, 16'h0001, 16'hAAAA);
      send_point(16'h8000, 16'h7FFF, 16'h1234, 16'h8000, 16'h4000, 16'h0001, 16'hAAAA);
      send_point(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_point(16'h0003, 16'hFFFD, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_point(16'h7FFF, 16'h8000, 16'h8000, 16'h00FF, 16'hFF00, 16'hFFFF, 16'h0000);
   endtask

   task automatic run_phase(int n);
      directed_points();
      repeat (n) random_point();
      idle_sender();
      wait_drained();
   endtask

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_phase(40);

      write_reg(CSR_MODE, 16'd4);
      write_reg(CSR_BRIGHTNESS, 16'hFFFF);
      write_reg(CSR_ALIGN, 16'd15);
      write_reg(CSR_MAX_STEP, 16'd0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      run_phase(40);

      // -16 lands outside the history and is clamped to -15
      write_reg(CSR_MODE, 16'd0);
      write_reg(CSR_BRIGHTNESS, 16'd384);
      write_reg(CSR_PER_AXIS, 16'hFFFF);
      write_reg(CSR_MAX_STEP, 16'd300);
      write_reg(CSR_MIN_STEP, 16'd200);
      write_reg(CSR_ALIGN, 16'hFFF0);
      run_phase(50);

      write_reg(CSR_PROT_OFF, 16'd1);
      write_reg(CSR_MODE, 16'hFFFF);
      write_reg(CSR_ALIGN, 16'h0007);
      run_phase(30);

      write_reg(CSR_PROT_OFF, 16'hFFFE);
      write_reg(CSR_MODE, 16'd1);
      write_reg(CSR_PER_AXIS, 16'd0);
      write_reg(CSR_MAX_STEP, 16'hFFFF);
      write_reg(CSR_MIN_STEP, 16'hFFFF);
      write_reg(CSR_BRIGHTNESS, 16'd0);
      write_reg(CSR_ALIGN, 16'h001D);
      run_phase(40);

      write_reg(CSR_MODE, 16'd2);
      write_reg(CSR_BRIGHTNESS, 16'd128);
      write_reg(CSR_MIN_STEP, 16'd50);
      write_reg(CSR_ALIGN, 16'd5);
      run_phase(40);

      write_reg(CSR_MODE, 16'd0);
      write_reg(CSR_MAX_STEP, 16'd700);
      write_reg(CSR_MIN_STEP, 16'd100);
      write_reg(CSR_BRIGHTNESS, 16'd256);
      write_reg(CSR_ALIGN, 16'hFFFD);
      run_phase(80);

      write_reg(CSR_PER_AXIS, 16'd1);
      write_reg(CSR_MIN_STEP, 16'd0);
      write_reg(CSR_BRIGHTNESS, 16'd1000);
      write_reg(CSR_ALIGN, 16'd0);
      run_phase(50);

      repeat (200) @(posedge clock);
      $display("Sent %0d points over eight register settings: 2D and per-axis slew,", points_sent);
      $display("dwell fade, unclamped gain, protection off and both alignment extremes.");
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/lpsg_pkg.sv
hdl/laser_point_scan_guard_unit.sv
tb/lpsg_checker.sv
tb/tb_laser_point_scan_guard_unit.sv
